// ===== design/mls_pkg.sv =====
// Shared types, constants and command codes of the moving least squares smoother.
package mls_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;

  localparam int CFG_W      = 24;
  localparam int DIV_STEPS  = 20;
  localparam int QDIV_STEPS = 16;
  localparam int MUL_DIGITS = 4;

  localparam logic [19:0] WEIGHT_MAX = 20'hFFFFF;
  localparam logic [15:0] VALUE_LOW  = 16'd409;
  localparam logic [15:0] VALUE_HIGH = 16'd40960;
  localparam logic [0:0]  CFG_PIVOT  = 1'b0;
  localparam logic [0:0]  CFG_EPS    = 1'b1;
  localparam logic [23:0] EPS_RESET  = 24'd147456;

  typedef struct packed {
    logic signed [15:0] x_value;
    logic [15:0]        y_value;
    logic               last_point;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] point_index;
    logic [15:0]      smoothed_value;
    logic             singular_fit;
    logic             last_result;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_WINIT, OP_DIV, OP_MAC1, OP_MAC2,
    OP_MULI, OP_MULS, OP_ND, OP_CHK, OP_CHK2, OP_QDIV
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PT, S_PT2, S_JRD, S_WINIT, S_DIV, S_MAC1, S_MAC2,
    S_MULI, S_MULS, S_ND, S_CHK, S_CHK2, S_QDIV, S_OUT
  } state_t;

  typedef struct packed {
    op_t              op;
    logic             wr;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    logic [1:0]       dig;
    logic [1:0]       sel;
    logic             pass;
  } cmd_t;

endpackage

// ===== design/mls_datapath.sv =====
// Sample stores, weight divider, sum accumulators, product and quotient units.
module mls_datapath (
  input  logic              clk,
  input  mls_pkg::cmd_t     cmd,
  input  mls_pkg::in_word_t in_word,
  input  logic [23:0]       eps2,
  output logic [15:0]       value,
  output logic              singular
);
  import mls_pkg::*;

  localparam logic [36:0] DIV_NUM = 37'h10_0000_0000;

  logic [15:0] xmem [MAX_POINTS];
  logic [15:0] ymem [MAX_POINTS];
  logic [15:0] rdx_r, rdy_r;

  logic signed [15:0] xi_r;
  logic [15:0]        yi_r, yj_r;
  logic signed [16:0] u_r;
  logic [31:0]        um2_r;
  logic               sat_r;
  logic [36:0]        rem_r;
  logic [51:0]        ds_r;
  logic [19:0]        q_r;

  logic signed [37:0] wu_r;
  logic [51:0]        wuu_r;
  logic [35:0]        wy_r;
  logic signed [63:0] s1_r, s2_r, s3_r, s4_r, s5_r;

  logic [63:0]         ma_r, mb_r;
  logic                neg_r;
  logic [127:0]        acc_r;
  logic signed [127:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [127:0] n_r, d_r, top_r, rest_r, qds_r;
  logic                sing_r, low_r, high_r;
  logic [15:0]         q16_r;

  // weight step
  logic signed [16:0] u, nu;
  logic [15:0]        um;
  logic [31:0]        um_sq;
  logic [32:0]        dr;
  logic [19:0]        w;
  logic               ge;
  assign u     = $signed({rdx_r[15], rdx_r}) - $signed({xi_r[15], xi_r});
  assign nu    = -u;
  assign um    = u[16] ? nu[15:0] : u[15:0];
  assign um_sq = um * um;
  assign dr    = {1'b0, um_sq} + {9'b0, eps2};
  assign w     = sat_r ? WEIGHT_MAX : q_r;
  assign ge    = {15'b0, rem_r} >= ds_r;

  // products
  logic signed [54:0] wuy;
  assign wuy = wu_r * $signed({1'b0, yj_r});

  logic signed [63:0] opa, opb;
  always_comb begin
    case (cmd.sel)
      2'd0:    begin opa = s1_r; opb = s2_r; end
      2'd1:    begin opa = s3_r; opb = s4_r; end
      2'd2:    begin opa = s5_r; opb = s2_r; end
      default: begin opa = s3_r; opb = s3_r; end
    endcase
  end

  logic [79:0]  part;
  logic [127:0] acc_nxt;
  assign part    = ma_r * mb_r[16*cmd.dig +: 16];
  assign acc_nxt = acc_r + ({48'b0, part} << {cmd.dig, 4'b0});

  logic signed [127:0] qt, hd;
  assign qt = rest_r - qds_r;
  assign hd = n_r - top_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      xmem[cmd.waddr] <= in_word.x_value;
      ymem[cmd.waddr] <= in_word.y_value;
    end
    rdx_r <= xmem[cmd.raddr];
    rdy_r <= ymem[cmd.raddr];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        xi_r <= rdx_r;
        yi_r <= rdy_r;
        s1_r <= '0; s2_r <= '0; s3_r <= '0; s4_r <= '0; s5_r <= '0;
      end
      OP_WINIT: begin
        u_r   <= u;
        um2_r <= um_sq;
        yj_r  <= rdy_r;
        sat_r <= dr <= 33'd65536;
        rem_r <= DIV_NUM;
        ds_r  <= {dr, 19'b0};
        q_r   <= '0;
      end
      OP_DIV: begin
        if (ge) rem_r <= rem_r - ds_r[36:0];
        q_r  <= {q_r[18:0], ge};
        ds_r <= ds_r >> 1;
      end
      OP_MAC1: begin
        wu_r  <= $signed({1'b0, w}) * u_r;
        wuu_r <= w * um2_r;
        wy_r  <= w * yj_r;
        s5_r  <= s5_r + {44'b0, w};
      end
      OP_MAC2: begin
        s3_r <= s3_r + {{26{wu_r[37]}}, wu_r};
        s2_r <= s2_r + {12'b0, wuu_r};
        s1_r <= s1_r + {28'b0, wy_r};
        s4_r <= s4_r + {{9{wuy[54]}}, wuy};
      end
      OP_MULI: begin
        ma_r  <= opa[63] ? -opa : opa;
        mb_r  <= opb[63] ? -opb : opb;
        neg_r <= opa[63] ^ opb[63];
        acc_r <= '0;
      end
      OP_MULS: begin
        acc_r <= acc_nxt;
        if (cmd.dig == 2'(MUL_DIGITS - 1)) begin
          case (cmd.sel)
            2'd0:    p0_r <= neg_r ? -acc_nxt : acc_nxt;
            2'd1:    p1_r <= neg_r ? -acc_nxt : acc_nxt;
            2'd2:    p2_r <= neg_r ? -acc_nxt : acc_nxt;
            default: p3_r <= neg_r ? -acc_nxt : acc_nxt;
          endcase
        end
      end
      OP_ND: begin
        n_r <= p0_r - p1_r;
        d_r <= p2_r - p3_r;
      end
      OP_CHK: begin
        top_r  <= (d_r <<< 15) + (d_r <<< 13);
        sing_r <= d_r == '0;
        low_r  <= n_r[127] || n_r == '0;
        rest_r <= n_r;
        qds_r  <= d_r <<< 15;
        q16_r  <= '0;
      end
      OP_CHK2: high_r <= !hd[127];
      OP_QDIV: begin
        if (!qt[127]) rest_r <= qt;
        q16_r <= {q16_r[14:0], !qt[127]};
        qds_r <= qds_r >>> 1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.pass) value = yi_r;
    else if (sing_r || low_r) value = VALUE_LOW;
    else if (high_r) value = VALUE_HIGH;
    else value = q16_r;
    singular = !cmd.pass && sing_r;
  end

endmodule

// ===== design/mls_ctrl.sv =====
// Sequencer: sample loading, per-point fit walk and result strobes.
module mls_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    last_point,
  input  logic [mls_pkg::IDX_W-1:0] pivot,
  output logic                    busy,
  output logic                    out_strobe,
  output logic [mls_pkg::IDX_W-1:0] out_index,
  output logic                    out_last,
  output mls_pkg::cmd_t           cmd
);
  import mls_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, n_r, n_nxt;
  logic [IDX_W-1:0] p_r, p_nxt, i_r, i_nxt, j_r, j_nxt, hi_r, hi_nxt;
  logic [4:0]       k_r, k_nxt;
  logic [1:0]       sel_r, sel_nxt;
  logic [IDX_W-1:0] nm1;

  assign nm1 = IDX_W'(n_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    n_r <= n_nxt; p_r <= p_nxt; i_r <= i_nxt; j_r <= j_nxt;
    hi_r <= hi_nxt; k_r <= k_nxt; sel_r <= sel_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; n_nxt = n_r; p_nxt = p_r; i_nxt = i_r;
    j_nxt = j_r; hi_nxt = hi_r; k_nxt = k_r; sel_nxt = sel_r;
    busy       = state_r != S_IDLE;
    out_strobe = 1'b0;
    out_index  = i_r;
    out_last   = i_r == nm1;
    cmd.op    = OP_NONE;
    cmd.wr    = 1'b0;
    cmd.waddr = cnt_r[IDX_W-1:0];
    cmd.raddr = i_r;
    cmd.dig   = k_r[1:0];
    cmd.sel   = sel_r;
    cmd.pass  = i_r == p_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.wr  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (last_point || cnt_r == CNT_W'(MAX_POINTS - 1)) begin
            n_nxt = cnt_r + 1'b1;
            p_nxt = (pivot > cnt_r[IDX_W-1:0]) ? cnt_r[IDX_W-1:0] : pivot;
            i_nxt = '0;
            state_nxt = S_PT;
          end
        end
      end
      S_PT: state_nxt = S_PT2;
      S_PT2: begin
        cmd.op = OP_LATCH;
        if (i_r == p_r) state_nxt = S_OUT;
        else begin
          j_nxt  = (i_r > p_r) ? p_r : '0;
          hi_nxt = (i_r > p_r) ? nm1 : p_r;
          state_nxt = S_JRD;
        end
      end
      S_JRD: begin
        cmd.raddr = j_r;
        state_nxt = S_WINIT;
      end
      S_WINIT: begin
        cmd.op = OP_WINIT;
        k_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        k_nxt = k_r + 1'b1;
        if (k_r == 5'(DIV_STEPS - 1)) state_nxt = S_MAC1;
      end
      S_MAC1: begin
        cmd.op = OP_MAC1;
        state_nxt = S_MAC2;
      end
      S_MAC2: begin
        cmd.op = OP_MAC2;
        if (j_r == hi_r) begin
          sel_nxt = '0;
          state_nxt = S_MULI;
        end else begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_JRD;
        end
      end
      S_MULI: begin
        cmd.op = OP_MULI;
        k_nxt = '0;
        state_nxt = S_MULS;
      end
      S_MULS: begin
        cmd.op = OP_MULS;
        k_nxt = k_r + 1'b1;
        if (k_r == 5'(MUL_DIGITS - 1)) begin
          sel_nxt = sel_r + 1'b1;
          state_nxt = (sel_r == 2'd3) ? S_ND : S_MULI;
        end
      end
      S_ND: begin
        cmd.op = OP_ND;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.op = OP_CHK;
        state_nxt = S_CHK2;
      end
      S_CHK2: begin
        cmd.op = OP_CHK2;
        k_nxt = '0;
        state_nxt = S_QDIV;
      end
      S_QDIV: begin
        cmd.op = OP_QDIV;
        k_nxt = k_r + 1'b1;
        if (k_r == 5'(QDIV_STEPS - 1)) state_nxt = S_OUT;
      end
      S_OUT: begin
        out_strobe = 1'b1;
        if (i_r == nm1) begin
          cnt_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_PT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== design/moving_least_squares_smoother_unit.sv =====
// Top level: config registers, sequencer and datapath of the smoother.
//
// Usage: samples enter as words on in_word, one accepted at each clock edge
// where start is high and busy is low. A word with last_point set, or the one
// that fills the 64th slot, closes the set and busy rises. One result word per
// stored point then comes out on out_word in index order, each valid for
// exactly one cycle while out_strobe is high; the receiver cannot stall it.
// Config (cfg_we/cfg_index/cfg_data: pivot index, eps squared) must be written
// by the user while busy is low, which the block does not enforce; unknown
// indexes are ignored. The pivot's result passes its own sample through.
// Every other point is fitted over m samples: each sample needs a read step,
// a setup step, a 20-step radix-2 weight divide and two multiply-accumulate
// steps; the four final products each take a load step and then one step per
// digit on a 64x16 multiplier over four digits, and the quotient takes 16
// steps.
// Reset (rst_n, synchronous) empties the set, returns to idle and restores
// pivot 0 and eps squared 2.25.
module moving_least_squares_smoother_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mls_pkg::in_word_t   in_word,
  output logic                out_strobe,
  output mls_pkg::out_word_t  out_word,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  import mls_pkg::*;

  logic [IDX_W-1:0] pivot_r;
  logic [23:0]      eps_r;
  cmd_t             cmd;
  logic [15:0]      value;
  logic             singular;
  logic [IDX_W-1:0] index;
  logic             last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_r <= '0;
      eps_r   <= EPS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIVOT: pivot_r <= cfg_data[IDX_W-1:0];
        CFG_EPS:   eps_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  mls_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .last_point (in_word.last_point),
    .pivot      (pivot_r),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_index  (index),
    .out_last   (last),
    .cmd        (cmd)
  );

  mls_datapath u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_word  (in_word),
    .eps2     (eps_r),
    .value    (value),
    .singular (singular)
  );

  always_comb begin
    out_word.point_index    = index;
    out_word.smoothed_value = value;
    out_word.singular_fit   = singular;
    out_word.last_result    = last;
  end

endmodule
